FILE: hw/rtl/mtme_pkg.sv
package mtme_pkg;

  localparam int unsigned KeyW = 76;

  localparam logic [1:0] OP_DATA  = 2'd0;
  localparam logic [1:0] OP_CTRL  = 2'd1;
  localparam logic [1:0] OP_PROBE = 2'd2;
  localparam logic [1:0] OP_NONE  = 2'd3;

  localparam logic [1:0] KIND_MPROBE = 2'd2;

  localparam logic [2:0] ACT_REQ_QUEUED  = 3'd0;
  localparam logic [2:0] ACT_CTRL_QUEUED = 3'd1;
  localparam logic [2:0] ACT_START_READ  = 3'd2;
  localparam logic [2:0] ACT_PROBE_FOUND = 3'd3;
  localparam logic [2:0] ACT_NOT_FOUND   = 3'd4;
  localparam logic [2:0] ACT_MPROBE_DONE = 3'd5;
  localparam logic [2:0] ACT_FULL        = 3'd6;

  typedef struct packed {
    logic [1:0]  op;
    logic [3:0]  iface;
    logic [15:0] comm_id;
    logic [23:0] src_rank;
    logic [31:0] msg_tag;
    logic [15:0] req_handle;
    logic [1:0]  req_kind;
    logic        has_info;
    logic [15:0] info_handle;
    logic [47:0] msg_size;
  } mtme_req_t;

  typedef struct packed {
    logic [2:0]  action;
    logic [15:0] out_req;
    logic [15:0] out_info;
    logic [47:0] out_size;
  } mtme_res_t;

  // command from the control sequencer to one table
  typedef struct packed {
    logic            remove;   // drop first hit, shift younger entries down
    logic            append;   // write into first free entry
    logic [KeyW-1:0] key;
    logic [63:0]     data;
  } mtme_cmd_t;

  // status from a table back to the sequencer
  typedef struct packed {
    logic        hit;
    logic        full;
    logic [63:0] hit_data;
  } mtme_sts_t;

endpackage

FILE: hw/rtl/mtme_cell.sv
module mtme_cell
  import mtme_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  input  mtme_cmd_t       cmd,
  input  logic            older_hit,   // some older cell already matched
  input  logic            older_free,  // some older cell is empty
  input  logic            up_valid,    // younger neighbor contents
  input  logic [KeyW-1:0] up_key,
  input  logic [63:0]     up_data,
  output logic            valid,
  output logic [KeyW-1:0] key,
  output logic [63:0]     data,
  output logic            hit
);

  logic shift_in;

  assign hit      = valid && (key == cmd.key);
  assign shift_in = cmd.remove && (older_hit || hit);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (shift_in) begin
      valid <= up_valid;
    end else if (cmd.append && !valid && !older_free) begin
      valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (shift_in) begin
      key  <= up_key;
      data <= up_data;
    end else if (cmd.append && !valid && !older_free) begin
      key  <= cmd.key;
      data <= cmd.data;
    end
  end

endmodule

FILE: hw/rtl/mtme_table.sv
module mtme_table
  import mtme_pkg::*;
#(
  parameter int unsigned DEPTH = 16
) (
  input  logic      clk,
  input  logic      rst,
  input  mtme_cmd_t cmd,
  output mtme_sts_t sts
);

  logic [DEPTH:0]  hit_chain;
  logic [DEPTH:0]  free_chain;
  logic [DEPTH-1:0] cv;
  logic [DEPTH-1:0] ch;
  logic [KeyW-1:0] ck [DEPTH];
  logic [63:0]     cd [DEPTH];
  logic [63:0]     sel [DEPTH+1];

  assign hit_chain[0]  = 1'b0;
  assign free_chain[0] = 1'b0;
  assign sel[0]        = '0;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic            uv;
    logic [KeyW-1:0] uk;
    logic [63:0]     ud;
    if (i == DEPTH - 1) begin : g_last
      assign uv = 1'b0;
      assign uk = ck[i];
      assign ud = cd[i];
    end else begin : g_mid
      assign uv = cv[i+1];
      assign uk = ck[i+1];
      assign ud = cd[i+1];
    end

    mtme_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .cmd        (cmd),
      .older_hit  (hit_chain[i]),
      .older_free (free_chain[i]),
      .up_valid   (uv),
      .up_key     (uk),
      .up_data    (ud),
      .valid      (cv[i]),
      .key        (ck[i]),
      .data       (cd[i]),
      .hit        (ch[i])
    );

    assign hit_chain[i+1]  = hit_chain[i] | ch[i];
    assign free_chain[i+1] = free_chain[i] | !cv[i];
    assign sel[i+1]        = (ch[i] && !hit_chain[i]) ? cd[i] : sel[i];
  end

  assign sts.hit      = hit_chain[DEPTH];
  assign sts.full     = !free_chain[DEPTH];
  assign sts.hit_data = sel[DEPTH];

endmodule

FILE: hw/rtl/message_tag_match_engine.sv
// Message tag match engine: two ordered match tables (control announcements
// waiting for data, requests waiting for a control message), each a row of
// cells that compare a key in parallel; the oldest hit wins and younger
// cells shift down one place on removal. A request is registered on
// acceptance, the tables are searched in SEARCH (the hit chain across the
// cell row sets the period), and in UPDATE the tables are updated and the
// result is registered. busy is high in SEARCH and UPDATE, so a new request
// can be taken in the cycle the result shows, not before the last one is
// through. The result shows for one cycle with result_valid and cannot be
// stalled. The user must write tag_mask with cfg_we only while idle; the
// block itself does not enforce it. An OP_NONE request gives no result.
module message_tag_match_engine
  import mtme_pkg::*;
#(
  parameter int unsigned CTRL_DEPTH = 16,
  parameter int unsigned WAIT_DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  mtme_req_t   req,
  output logic        result_valid,
  output mtme_res_t   result,
  input  logic        cfg_we,
  input  logic [31:0] cfg_data
);

  typedef enum logic [1:0] {IDLE, SEARCH, UPDATE} state_t;

  state_t      state;
  logic [31:0] tag_mask;
  mtme_req_t   r;
  logic [KeyW-1:0] key;
  mtme_cmd_t   ccmd, wcmd;
  mtme_sts_t   csts, wsts;
  mtme_res_t   res_next;
  logic        c_rm, c_ap, w_rm, w_ap;

  // masked key of the registered request
  assign key = {r.iface, r.comm_id, r.src_rank, r.msg_tag & tag_mask};

  // decide outcome from the search status
  always_comb begin
    res_next = '0;
    c_rm = 1'b0; c_ap = 1'b0; w_rm = 1'b0; w_ap = 1'b0;
    case (r.op)
      OP_DATA: begin
        res_next.out_req = r.req_handle;
        if (r.has_info) begin
          res_next.action   = ACT_START_READ;
          res_next.out_info = r.info_handle;
        end else if (csts.hit) begin
          res_next.action   = ACT_START_READ;
          res_next.out_info = csts.hit_data[63:48];
          c_rm = 1'b1;
        end else if (wsts.full) begin
          res_next.action = ACT_FULL;
        end else begin
          res_next.action = ACT_REQ_QUEUED;
          w_ap = 1'b1;
        end
      end
      OP_CTRL: begin
        res_next.out_info = r.info_handle;
        if (wsts.hit) begin
          res_next.out_req = wsts.hit_data[15:0];
          w_rm = 1'b1;
          if (wsts.hit_data[17:16] == KIND_MPROBE) begin
            res_next.action   = ACT_MPROBE_DONE;
            res_next.out_size = r.msg_size;
          end else begin
            res_next.action = ACT_START_READ;
          end
        end else if (csts.full) begin
          res_next.action = ACT_FULL;
        end else begin
          res_next.action = ACT_CTRL_QUEUED;
          c_ap = 1'b1;
        end
      end
      default: begin
        res_next.out_req = r.req_handle;
        if (csts.hit) begin
          res_next.out_size = csts.hit_data[47:0];
          if (r.req_kind == KIND_MPROBE) begin
            res_next.action   = ACT_MPROBE_DONE;
            res_next.out_info = csts.hit_data[63:48];
            c_rm = 1'b1;
          end else begin
            res_next.action = ACT_PROBE_FOUND;
          end
        end else if (r.req_kind == KIND_MPROBE) begin
          if (wsts.full) begin
            res_next.action = ACT_FULL;
          end else begin
            res_next.action = ACT_REQ_QUEUED;
            w_ap = 1'b1;
          end
        end else begin
          res_next.action = ACT_NOT_FOUND;
        end
      end
    endcase
  end

  // table commands act only in the update cycle
  always_comb begin
    ccmd.remove = (state == UPDATE) && c_rm;
    ccmd.append = (state == UPDATE) && c_ap;
    ccmd.key    = key;
    ccmd.data   = {r.info_handle, r.msg_size};
    wcmd.remove = (state == UPDATE) && w_rm;
    wcmd.append = (state == UPDATE) && w_ap;
    wcmd.key    = key;
    wcmd.data   = {46'd0, r.req_kind, r.req_handle};
  end

  mtme_table #(.DEPTH(CTRL_DEPTH)) u_ctrl (
    .clk (clk), .rst (rst), .cmd (ccmd), .sts (csts)
  );

  mtme_table #(.DEPTH(WAIT_DEPTH)) u_wait (
    .clk (clk), .rst (rst), .cmd (wcmd), .sts (wsts)
  );

  assign busy = (state != IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= IDLE;
      tag_mask     <= '1;
      result_valid <= 1'b0;
    end else begin
      result_valid <= 1'b0;
      if (cfg_we) begin
        tag_mask <= cfg_data;
      end
      unique case (state)
        IDLE: begin
          if (start) begin
            state <= SEARCH;
          end
        end
        SEARCH: begin
          // outcome is formed from the search and applied next cycle
          state <= (r.op == OP_NONE) ? IDLE : UPDATE;
        end
        UPDATE: begin
          state        <= IDLE;
          result_valid <= 1'b1;
        end
        default: state <= IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == IDLE && start) begin
      r <= req;
    end
    if (state == UPDATE) begin
      result <= res_next;
    end
  end

endmodule
